>>> sv/head_scan_track_sequencer_unit_defines.svh
// ----------------------------------------------------------------------------
// head_scan_track_sequencer_unit_defines
// Assertion macros shared by the sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef HEAD_SCAN_TRACK_SEQUENCER_UNIT_DEFINES_SVH
`define HEAD_SCAN_TRACK_SEQUENCER_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define HSTS_ASSERT_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("hsts: same-cycle check failed");

// next-cycle implication, disabled in reset
`define HSTS_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("hsts: next-cycle check failed");

`endif

>>> sv/hsts_pkg.sv
// ----------------------------------------------------------------------------
// hsts_pkg
// Types, constants and the ball search point table of the head sequencer.
// ----------------------------------------------------------------------------
package hsts_pkg;

	localparam int ANGLE_FRAC_BITS = 4;
	localparam int ONE_DEG         = 1 << ANGLE_FRAC_BITS;
	localparam int HALF_DEG        = 1 << (ANGLE_FRAC_BITS - 1);
	localparam int SWEEP_LIMIT     = 90 * ONE_DEG + ONE_DEG / 10;
	localparam int SWEEP_START_INT = -90 * ONE_DEG;
	localparam int SWEEP_TURN_INT  = 90 * ONE_DEG;
	localparam int POST_PITCH_INT  = 30 * ONE_DEG;
	localparam int YAW_MARGIN_INT  = 30 * ONE_DEG;

	localparam int ANG_W  = 13;
	localparam int WIDE_W = ANG_W + 1;
	localparam int OFS_W  = 12;
	localparam int U11_W  = 11;
	localparam int PT_W   = 4;
	localparam int ANG_MAX = (1 << (ANG_W - 1)) - 1;
	localparam int ANG_MIN = -(1 << (ANG_W - 1));

	localparam int CFG_W      = 13;
	localparam int CFG_ADDR_W = 3;
	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 32;

	typedef logic signed [ANG_W-1:0]  ang_t;
	typedef logic signed [WIDE_W-1:0] ang_wide_t;
	typedef logic signed [OFS_W-1:0]  ofs_t;
	typedef logic [U11_W-1:0]         u11_t;
	typedef logic [PT_W-1:0]          point_t;

	typedef enum logic [1:0] {
		MODE_LOOK  = 2'd0,
		MODE_BALL  = 2'd1,
		MODE_POST  = 2'd2,
		MODE_TRACK = 2'd3
	} mode_t;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_YAW_MIN   = 3'd0,
		REG_YAW_MAX   = 3'd1,
		REG_PITCH_MIN = 3'd2,
		REG_PITCH_MAX = 3'd3,
		REG_POST_STEP = 3'd4,
		REG_DEADBAND  = 3'd5
	} reg_idx_t;

	localparam point_t BALL_POINT_LAST = PT_W'(11);
	localparam ang_t   SWEEP_START     = ANG_W'(SWEEP_START_INT);
	localparam ang_t   SWEEP_TURN      = ANG_W'(SWEEP_TURN_INT);
	localparam ang_t   SWEEP_HI        = ANG_W'(SWEEP_LIMIT);
	localparam ang_t   SWEEP_LO        = ANG_W'(-SWEEP_LIMIT);
	localparam ang_t   POST_PITCH      = ANG_W'(POST_PITCH_INT);

	typedef struct packed {
		ang_t yaw_min;
		ang_t yaw_max;
		ang_t pitch_min;
		ang_t pitch_max;
		u11_t post_step;
		u11_t deadband;
	} cfg_t;

	typedef struct packed {
		mode_t  mode;
		ang_t   look_yaw;
		ang_t   look_pitch;
		point_t ball_point;
		logic   sweep_phase;
		ang_t   sweep_yaw;
	} state_t;

	typedef struct packed {
		logic  op;
		ang_t  cmd_yaw;
		ang_t  cmd_pitch;
		mode_t cmd_mode;
		logic  ball_seen;
		ofs_t  ball_alpha;
		ofs_t  ball_beta;
		logic  post_seen;
		ang_t  head_yaw;
		ang_t  head_pitch;
	} item_t;

	typedef struct packed {
		ang_t  target_yaw;
		ang_t  target_pitch;
		mode_t mode_now;
	} result_t;

	// search point yaw, table in half degrees
	function automatic ang_t ball_point_yaw(input point_t idx);
		int v;
		case (idx)
			4'd0:    v = 200;
			4'd1:    v = 100;
			4'd2:    v = 0;
			4'd3:    v = -100;
			4'd4:    v = -200;
			4'd5:    v = -170;
			4'd6:    v = -55;
			4'd7:    v = 55;
			4'd8:    v = 170;
			4'd9:    v = 100;
			4'd10:   v = 0;
			4'd11:   v = -100;
			default: v = 0;
		endcase
		return ANG_W'(v * HALF_DEG);
	endfunction

	// search point pitch, table in degrees
	function automatic ang_t ball_point_pitch(input point_t idx);
		int v;
		case (idx)
			4'd5, 4'd6, 4'd7, 4'd8: v = 30;
			4'd9, 4'd10, 4'd11:     v = 60;
			default:                v = 0;
		endcase
		return ANG_W'(v * ONE_DEG);
	endfunction

	// saturate a widened angle into the output range
	function automatic ang_t ang_sat(input ang_wide_t x);
		ang_t r;
		if (x > WIDE_W'(ANG_MAX)) begin
			r = ANG_W'(ANG_MAX);
		end else if (x < WIDE_W'(ANG_MIN)) begin
			r = ANG_W'(ANG_MIN);
		end else begin
			r = x[ANG_W-1:0];
		end
		return r;
	endfunction

endpackage

>>> sv/hsts_step.sv
// ----------------------------------------------------------------------------
// hsts_step
// One item of the sequencer: next state and setpoint from state and item.
// ----------------------------------------------------------------------------
module hsts_step (
	input  hsts_pkg::cfg_t    cfg,
	input  hsts_pkg::state_t  cur,
	input  hsts_pkg::item_t   item,
	output hsts_pkg::state_t  nxt,
	output hsts_pkg::result_t res
);
	import hsts_pkg::*;

	logic [OFS_W-1:0] alpha_mag;
	logic [OFS_W-1:0] beta_mag;
	ang_wide_t        trk_yaw_raw;
	ang_wide_t        trk_pitch_raw;
	ang_wide_t        yaw_hi;
	ang_wide_t        yaw_lo;
	ang_wide_t        trk_yaw_hc;
	ang_wide_t        trk_yaw_c;
	ang_wide_t        trk_pitch_hc;
	ang_wide_t        trk_pitch_c;
	ang_t             step_s;
	logic             sweep_in;

	// track setpoint: nudge by one degree per axis beyond the deadband, then clamp (upper first)
	always_comb begin
		alpha_mag = item.ball_alpha[OFS_W-1] ? OFS_W'(-item.ball_alpha) : OFS_W'(item.ball_alpha);
		beta_mag  = item.ball_beta[OFS_W-1] ? OFS_W'(-item.ball_beta) : OFS_W'(item.ball_beta);

		trk_yaw_raw   = WIDE_W'(item.head_yaw);
		trk_pitch_raw = WIDE_W'(item.head_pitch);
		if (alpha_mag > OFS_W'(cfg.deadband)) begin
			trk_yaw_raw = item.ball_alpha[OFS_W-1] ? trk_yaw_raw + WIDE_W'(ONE_DEG)
			                                       : trk_yaw_raw - WIDE_W'(ONE_DEG);
		end
		if (beta_mag > OFS_W'(cfg.deadband)) begin
			trk_pitch_raw = item.ball_beta[OFS_W-1] ? trk_pitch_raw - WIDE_W'(ONE_DEG)
			                                        : trk_pitch_raw + WIDE_W'(ONE_DEG);
		end

		yaw_hi = WIDE_W'(cfg.yaw_max) - WIDE_W'(YAW_MARGIN_INT);
		yaw_lo = WIDE_W'(cfg.yaw_min) + WIDE_W'(YAW_MARGIN_INT);
		trk_yaw_hc   = (trk_yaw_raw > yaw_hi) ? yaw_hi : trk_yaw_raw;
		trk_yaw_c    = (trk_yaw_hc < yaw_lo) ? yaw_lo : trk_yaw_hc;
		trk_pitch_hc = (trk_pitch_raw > WIDE_W'(cfg.pitch_max)) ? WIDE_W'(cfg.pitch_max)
		                                                        : trk_pitch_raw;
		trk_pitch_c  = (trk_pitch_hc < WIDE_W'(cfg.pitch_min)) ? WIDE_W'(cfg.pitch_min)
		                                                       : trk_pitch_hc;
	end

	assign step_s   = ang_t'({2'b00, cfg.post_step});
	assign sweep_in = (cur.sweep_yaw >= SWEEP_LO) && (cur.sweep_yaw <= SWEEP_HI);

	always_comb begin
		nxt              = cur;
		res.target_yaw   = cur.look_yaw;
		res.target_pitch = cur.look_pitch;

		if (item.op) begin
			nxt.look_yaw    = item.cmd_yaw;
			nxt.look_pitch  = item.cmd_pitch;
			nxt.mode        = item.cmd_mode;
			nxt.ball_point  = BALL_POINT_LAST;
			nxt.sweep_phase = 1'b0;
			nxt.sweep_yaw   = SWEEP_START;
		end else begin
			case (cur.mode)
				MODE_LOOK: begin
				end
				MODE_BALL: begin
					if (item.ball_seen) begin
						nxt.mode         = MODE_TRACK;
						res.target_yaw   = ang_sat(trk_yaw_c);
						res.target_pitch = ang_sat(trk_pitch_c);
					end else if (cur.ball_point <= BALL_POINT_LAST) begin
						res.target_yaw   = ball_point_yaw(cur.ball_point);
						res.target_pitch = ball_point_pitch(cur.ball_point);
						nxt.ball_point   = cur.ball_point - PT_W'(1);
					end else begin
						nxt.mode = MODE_LOOK;
					end
					if (item.ball_seen || cur.ball_point > BALL_POINT_LAST) begin
						nxt.ball_point  = BALL_POINT_LAST;
						nxt.sweep_phase = 1'b0;
						nxt.sweep_yaw   = SWEEP_START;
					end
				end
				MODE_POST: begin
					if (!item.post_seen && !cur.sweep_phase && sweep_in) begin
						res.target_yaw   = cur.sweep_yaw;
						res.target_pitch = POST_PITCH;
						nxt.sweep_yaw    = cur.sweep_yaw + step_s;
					end else if (!item.post_seen && !cur.sweep_phase) begin
						// first sweep done: second sweep starts at +90 deg
						res.target_yaw   = SWEEP_TURN;
						res.target_pitch = '0;
						nxt.sweep_phase  = 1'b1;
						nxt.sweep_yaw    = SWEEP_TURN - step_s;
					end else if (!item.post_seen && sweep_in) begin
						res.target_yaw   = cur.sweep_yaw;
						res.target_pitch = '0;
						nxt.sweep_yaw    = cur.sweep_yaw - step_s;
					end else begin
						nxt.mode        = MODE_LOOK;
						nxt.ball_point  = BALL_POINT_LAST;
						nxt.sweep_phase = 1'b0;
						nxt.sweep_yaw   = SWEEP_START;
					end
				end
				MODE_TRACK: begin
					res.target_yaw   = ang_sat(trk_yaw_c);
					res.target_pitch = ang_sat(trk_pitch_c);
				end
				default: begin
				end
			endcase
		end

		res.mode_now = nxt.mode;
	end

endmodule

>>> sv/head_scan_track_sequencer_unit.sv
// ----------------------------------------------------------------------------
// head_scan_track_sequencer_unit
// Pan/tilt head aiming sequencer: look-at, ball search, post search, track.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one item per transfer. s_tuser = 1 is a command
//   (look-at angles and mode; restarts searches, gives no result);
//   s_tuser = 0 is a tick carrying ball/post observations and head angles,
//   and gives exactly one setpoint transfer on the output stream (m_*).
//   Config: cfg_we/cfg_addr/cfg_wdata write the limit, step and deadband
//   registers; write only while the block is idle.
//   Path: an accepted tick goes through the input register, then the result
//   register, before its setpoint shows at m_tdata.
//   Throughput: one item per cycle while the output is not stalled, set by
//   the single pass through the step logic between the input and result registers.
//   Stall: while m_tready is low with a setpoint held, one more item may
//   sit in the input register; a command there still completes, a tick
//   there holds s_tready low until the result register drains.
//   Reset (arst_n low): state, config and valid registers reset, mode is
//   look-at at angle zero, both streams empty.
// ----------------------------------------------------------------------------
`include "head_scan_track_sequencer_unit_defines.svh"

module head_scan_track_sequencer_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	// config write port
	input  logic                               cfg_we,
	input  logic [hsts_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [hsts_pkg::CFG_W-1:0]         cfg_wdata,
	// input stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// s_tdata, low bit up: cmd_yaw[13], cmd_pitch[13], cmd_mode[2], ball_seen[1],
	// ball_alpha[12], ball_beta[12], post_seen[1], head_yaw[13], head_pitch[13]
	input  logic [hsts_pkg::IN_DATA_W-1:0]     s_tdata,
	// s_tuser: op[1] (1 command, 0 tick)
	input  logic                               s_tuser,
	// output stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// m_tdata, low bit up: target_yaw[13], target_pitch[13], mode_now[2], zero pad[4]
	output logic [hsts_pkg::OUT_DATA_W-1:0]    m_tdata
);
	import hsts_pkg::*;

	cfg_t    cfg_q;
	state_t  state_q;
	state_t  state_nxt;
	item_t   in_item;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_step;
	result_t res_s2;
	logic    valid_s2;
	logic    adv;
	logic    in_xfer;

	// unpack input transfer
	always_comb begin
		in_item.op         = s_tuser;
		in_item.cmd_yaw    = s_tdata[12:0];
		in_item.cmd_pitch  = s_tdata[25:13];
		in_item.cmd_mode   = mode_t'(s_tdata[27:26]);
		in_item.ball_seen  = s_tdata[28];
		in_item.ball_alpha = s_tdata[40:29];
		in_item.ball_beta  = s_tdata[52:41];
		in_item.post_seen  = s_tdata[53];
		in_item.head_yaw   = s_tdata[66:54];
		in_item.head_pitch = s_tdata[79:67];
	end

	// a command needs no output slot; a tick needs the result register free
	assign adv      = valid_s1 && (item_s1.op || !valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign in_xfer  = s_tvalid && s_tready;

	hsts_step u_step (
		.cfg  (cfg_q),
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res_step)
	);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.yaw_min   <= ANG_W'(-1600);
			cfg_q.yaw_max   <= ANG_W'(1600);
			cfg_q.pitch_min <= '0;
			cfg_q.pitch_max <= ANG_W'(960);
			cfg_q.post_step <= U11_W'(160);
			cfg_q.deadband  <= U11_W'(51);
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_addr))
				REG_YAW_MIN:   cfg_q.yaw_min   <= cfg_wdata[ANG_W-1:0];
				REG_YAW_MAX:   cfg_q.yaw_max   <= cfg_wdata[ANG_W-1:0];
				REG_PITCH_MIN: cfg_q.pitch_min <= cfg_wdata[ANG_W-1:0];
				REG_PITCH_MAX: cfg_q.pitch_max <= cfg_wdata[ANG_W-1:0];
				REG_POST_STEP: cfg_q.post_step <= cfg_wdata[U11_W-1:0];
				REG_DEADBAND:  cfg_q.deadband  <= cfg_wdata[U11_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer state, updated as the item in the input register retires
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode        <= MODE_LOOK;
			state_q.look_yaw    <= '0;
			state_q.look_pitch  <= '0;
			state_q.ball_point  <= BALL_POINT_LAST;
			state_q.sweep_phase <= 1'b0;
			state_q.sweep_yaw   <= SWEEP_START;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1 <= in_item;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv && !item_s1.op) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && !item_s1.op) begin
			res_s2 <= res_step;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {4'b0000, res_s2.mode_now, res_s2.target_pitch, res_s2.target_yaw};

	// a command never loads the result register
	`HSTS_ASSERT_NEXT(a_cmd_no_result, clk, arst_n, adv && item_s1.op, m_tvalid == $past(m_tvalid && !m_tready))
	// reported mode matches the retired state
	`HSTS_ASSERT_NEXT(a_mode_now_match, clk, arst_n, adv && !item_s1.op, m_tdata[27:26] == state_q.mode)
	// ball point parked outside ball search
	`HSTS_ASSERT_NOW(a_point_parked, clk, arst_n, state_q.mode != MODE_BALL, state_q.ball_point == BALL_POINT_LAST)
	// sweep parked outside post search
	`HSTS_ASSERT_NOW(a_sweep_parked, clk, arst_n, state_q.mode != MODE_POST, !state_q.sweep_phase && state_q.sweep_yaw == SWEEP_START)
	// input side only stalls behind a held setpoint
	`HSTS_ASSERT_NOW(a_stall_cause, clk, arst_n, !s_tready, valid_s1 && m_tvalid && !m_tready)

endmodule
